// ===== src/lfp_pkg.sv =====
package lfp_pkg;

	localparam int unsigned MAX_CHECK_CHARS = 9;
	localparam int unsigned CHECK_CNT_W = 4;

	localparam logic [7:0] DEVICE_ID_RESET = 8'd76;

	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UC_C   = 8'h43;
	localparam logic [7:0] CH_UC_L   = 8'h4C;
	localparam logic [7:0] CH_UC_O   = 8'h4F;
	localparam logic [7:0] CH_UC_S   = 8'h53;
	localparam logic [7:0] CH_UC_E   = 8'h45;
	localparam logic [7:0] CH_UC_D   = 8'h44;

	localparam logic signed [15:0] DIGIT_BIAS = 16'sd48;
	localparam logic signed [15:0] LEVEL_MAX  = 16'sd100;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_LEVEL  = 2'd1,
		EV_ERROR  = 2'd2,
		EV_CLOSED = 2'd3
	} event_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'd0,
		ST_DEVICE = 4'd1,
		ST_HUND   = 4'd2,
		ST_TENS   = 4'd3,
		ST_UNITS  = 4'd4,
		ST_CHECK  = 4'd5,
		ST_CL_L   = 4'd6,
		ST_CL_O   = 4'd7,
		ST_CL_S   = 4'd8,
		ST_CL_E   = 4'd9,
		ST_CL_D   = 4'd10
	} frame_state_t;

endpackage

// ===== src/lfp_rx_if.sv =====
interface lfp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== src/lfp_res_if.sv =====
interface lfp_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_res;
	logic [6:0] level;

	modport source (output valid, output event_res, output level, input ready);
	modport sink (input valid, input event_res, input level, output ready);
endinterface

// ===== src/lfp_cfg_if.sv =====
interface lfp_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] device_id;

	modport source (output valid, output device_id, input ready);
	modport sink (input valid, input device_id, output ready);
endinterface

// ===== src/level_frame_parser.sv =====
// Parses level frames ('#', device byte, three level digits, decimal checksum, '$') and the
// link-closed message "CLOSED" from a byte stream, one result word for every byte word. A byte
// is taken every cycle while the output is not stalled. Each byte passes one input register
// and one result register, with the frame state updated in the single step between them.
// The device byte is compared against the device_id register, written through the
// configuration channel; the user must write it only while the parser is idle, and the block
// itself does not enforce this.
module level_frame_parser
	import lfp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	lfp_rx_if.sink    rx,
	lfp_res_if.source res,
	lfp_cfg_if.sink   cfg
);

	logic [7:0]             device_id_q;

	logic                   valid_s1;
	logic [7:0]             byte_s1;

	logic                   valid_s2;
	event_t                 event_s2;
	logic [6:0]             level_s2;

	frame_state_t           state_q, state_d;
	logic [7:0]             xor_q, xor_d;
	logic [7:0]             hund_q, hund_d;
	logic [7:0]             tens_q, tens_d;
	logic [7:0]             units_q, units_d;
	logic [7:0]             check_q, check_d;
	logic                   stopped_q, stopped_d;
	logic [CHECK_CNT_W-1:0] count_q, count_d;

	event_t                 event_d;
	logic [6:0]             level_d;

	logic                   advance;
	logic                   step;
	logic                   is_digit;
	logic signed [15:0]     level_v;
	logic [7:0]             check_next;

	assign advance = !valid_s2 || res.ready;
	assign step = valid_s1 && advance;
	assign rx.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	assign res.valid = valid_s2;
	assign res.event_res = event_s2;
	assign res.level = level_s2;

	assign is_digit = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
	assign check_next = 8'({check_q, 3'b000} + {check_q, 1'b0} + (byte_s1 - CH_ZERO));
	assign level_v = ($signed({8'd0, hund_q}) - DIGIT_BIAS) * 16'sd100
		+ ($signed({8'd0, tens_q}) - DIGIT_BIAS) * 16'sd10
		+ ($signed({8'd0, units_q}) - DIGIT_BIAS);

	always_comb begin
		state_d = ST_IDLE;
		xor_d = xor_q;
		hund_d = hund_q;
		tens_d = tens_q;
		units_d = units_q;
		check_d = check_q;
		stopped_d = stopped_q;
		count_d = count_q;
		unique case (state_q)
			ST_DEVICE: begin
				if (byte_s1 == device_id_q) begin
					xor_d = byte_s1;
					state_d = ST_HUND;
				end
			end
			ST_HUND: begin
				hund_d = byte_s1;
				xor_d = xor_q ^ byte_s1;
				state_d = ST_TENS;
			end
			ST_TENS: begin
				tens_d = byte_s1;
				xor_d = xor_q ^ byte_s1;
				state_d = ST_UNITS;
			end
			ST_UNITS: begin
				units_d = byte_s1;
				xor_d = xor_q ^ byte_s1;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (byte_s1 != CH_DOLLAR) begin
					state_d = ST_CHECK;
					if (!stopped_q) begin
						if (is_digit) begin
							if (count_q < CHECK_CNT_W'(MAX_CHECK_CHARS)) begin
								check_d = check_next;
								count_d = count_q + 1'b1;
							end
						end else begin
							stopped_d = 1'b1;
						end
					end
				end else begin
					check_d = '0;
					stopped_d = 1'b0;
					count_d = '0;
				end
			end
			ST_CL_L: state_d = (byte_s1 == CH_UC_L) ? ST_CL_O : ST_IDLE;
			ST_CL_O: state_d = (byte_s1 == CH_UC_O) ? ST_CL_S : ST_IDLE;
			ST_CL_S: state_d = (byte_s1 == CH_UC_S) ? ST_CL_E : ST_IDLE;
			ST_CL_E: state_d = (byte_s1 == CH_UC_E) ? ST_CL_D : ST_IDLE;
			ST_CL_D: state_d = ST_IDLE;
			default: begin
				if (byte_s1 == CH_HASH) begin
					check_d = '0;
					stopped_d = 1'b0;
					count_d = '0;
					state_d = ST_DEVICE;
				end else if (byte_s1 == CH_UC_C) begin
					state_d = ST_CL_L;
				end
			end
		endcase
	end

	always_comb begin
		event_d = EV_NONE;
		level_d = '0;
		unique case (state_q)
			ST_CHECK: begin
				if (byte_s1 == CH_DOLLAR) begin
					if (check_q != xor_q || level_v < 16'sd0 || level_v > LEVEL_MAX) begin
						event_d = EV_ERROR;
					end else begin
						event_d = EV_LEVEL;
						level_d = level_v[6:0];
					end
				end
			end
			ST_CL_D: begin
				if (byte_s1 == CH_UC_D) begin
					event_d = EV_CLOSED;
				end
			end
			default: begin
				event_d = EV_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_id_q <= DEVICE_ID_RESET;
		end else if (cfg.valid && cfg.ready) begin
			device_id_q <= cfg.device_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			event_s2 <= event_d;
			level_s2 <= level_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			xor_q <= '0;
			hund_q <= '0;
			tens_q <= '0;
			units_q <= '0;
			check_q <= '0;
			stopped_q <= 1'b0;
			count_q <= '0;
		end else if (step) begin
			state_q <= state_d;
			xor_q <= xor_d;
			hund_q <= hund_d;
			tens_q <= tens_d;
			units_q <= units_d;
			check_q <= check_d;
			stopped_q <= stopped_d;
			count_q <= count_d;
		end
	end

`ifndef SYNTHESIS
	a_level_only_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && event_s2 != EV_LEVEL) |-> (level_s2 == 7'd0))
		else $error("level is nonzero on a result word that is not an accepted level");

	a_level_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && event_s2 == EV_LEVEL) |-> (level_s2 <= 7'd100))
		else $error("accepted level lies above 100");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CHECK_CNT_W'(MAX_CHECK_CHARS))
		else $error("checksum digit count exceeds its limit");

	a_event_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(step && event_d != EV_NONE) |=> (state_q == ST_IDLE && count_q == '0))
		else $error("parser did not return to idle after reporting an event");
`endif

endmodule
